[design/box_filter_downsampler_macros.svh]
// Assertion macros for the port checker of the box filter downsampler.
// Depends on nothing; included by the port checker.
`ifndef BOX_FILTER_DOWNSAMPLER_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLER_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define BFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define BFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define BFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bfd_pkg.sv]
// Shared types, constants and width helpers of the box filter downsampler.
// Depends on nothing; used by the controller, the datapath and the top level.
package bfd_pkg;

   localparam int PIXEL_W        = 24;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 3;
   localparam int CHAN_MAX       = 255;
   localparam int MAX_OUT_HEIGHT = 2048;
   localparam int ROW_W          = 11;
   localparam int AA_REG_W       = 4;
   localparam int SIZE_REG_W     = 12;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;

   localparam logic [AA_REG_W-1:0]   AA_RESET     = 4'd1;
   localparam logic [SIZE_REG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET = 12'd480;

   typedef enum logic [1:0] {
      REG_AA_FACTOR  = 2'd0,
      REG_OUT_WIDTH  = 2'd1,
      REG_OUT_HEIGHT = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic sum_wr;
      logic mul;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_done;
      logic emit;
   } dp_status_type;

   function automatic int sub_width(int max_aa);
      return (max_aa > 1) ? $clog2(max_aa) : 1;
   endfunction

   function automatic int col_width(int max_out_width);
      return (max_out_width > 1) ? $clog2(max_out_width) : 1;
   endfunction

   // A column sum never needs more than 255 * MAX_AA^2.
   function automatic int sum_width(int max_aa);
      return $clog2(CHAN_MAX * max_aa * max_aa + 1);
   endfunction

   // The reciprocal shift keeps floor(sum * recip >> shift) exact for every sum.
   function automatic int shift_width(int max_aa);
      return sum_width(max_aa) + $clog2(max_aa * max_aa + 1);
   endfunction

endpackage

[design/box_filter_downsampler.sv]
// Top level of the box filter downsampler: configuration registers, reciprocal table,
// controller and datapath. Depends on bfd_pkg, bfd_ctrl and bfd_dpath.
//
//   Channel   Direction  Contents
//   req_*     in         supersampled pixels in raster order
//   rsp_*     out        block averages with row and frame end marks
//   csr_*     in/out     APB registers aa_factor, out_width, out_height
//
// A pixel that closes no block passes through the states IDLE and SUM; one that closes
// a block goes on through MUL and EMIT for the registered multiply and the output load.
// After reset a clearing pass zeroes every address of the sum memory, with req_tready
// low. A full output register stalls a block result only in its last step.
module box_filter_downsampler #(
   parameter int MAX_OUT_WIDTH = 2048,
   parameter int MAX_AA        = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bfd_pkg::PIXEL_W-1:0]        req_tdata,   // [23:0] pixel_color
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bfd_pkg::PIXEL_W-1:0]        rsp_tdata,   // [23:0] avg_color
   output logic                               rsp_tlast,   // row_end
   output logic [0:0]                         rsp_tuser,   // [0] frame_end
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bfd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bfd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SUB_W   = bfd_pkg::sub_width(MAX_AA);
   localparam int COL_W   = bfd_pkg::col_width(MAX_OUT_WIDTH);
   localparam int SHIFT   = bfd_pkg::shift_width(MAX_AA);
   localparam int RECIP_W = SHIFT + 1;

   logic [bfd_pkg::AA_REG_W-1:0]   aa_ff;
   logic [bfd_pkg::SIZE_REG_W-1:0] width_ff, height_ff;
   logic                           csr_wr;
   bfd_pkg::csr_index_type         csr_index;

   logic [31:0]               aa_eff, width_eff, height_eff;
   logic [SUB_W-1:0]          aa_last;
   logic [COL_W-1:0]          width_last;
   logic [bfd_pkg::ROW_W-1:0] height_last;
   logic [RECIP_W-1:0]        recip_table [MAX_AA];
   logic [RECIP_W-1:0]        recip_ff;

   bfd_pkg::dp_cmd_type    cmd;
   bfd_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_index  = bfd_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         aa_ff     <= bfd_pkg::AA_RESET;
         width_ff  <= bfd_pkg::WIDTH_RESET;
         height_ff <= bfd_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            bfd_pkg::REG_AA_FACTOR:  aa_ff     <= csr_pwdata[bfd_pkg::AA_REG_W-1:0];
            bfd_pkg::REG_OUT_WIDTH:  width_ff  <= csr_pwdata[bfd_pkg::SIZE_REG_W-1:0];
            bfd_pkg::REG_OUT_HEIGHT: height_ff <= csr_pwdata[bfd_pkg::SIZE_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bfd_pkg::REG_AA_FACTOR:  csr_prdata = bfd_pkg::CSR_DATA_W'(aa_ff);
         bfd_pkg::REG_OUT_WIDTH:  csr_prdata = bfd_pkg::CSR_DATA_W'(width_ff);
         bfd_pkg::REG_OUT_HEIGHT: csr_prdata = bfd_pkg::CSR_DATA_W'(height_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Zero acts as one and oversized values clamp to the supported maximum.
   always_comb begin
      if (aa_ff == '0) begin
         aa_eff = 32'd1;
      end else if (32'(aa_ff) > 32'(MAX_AA)) begin
         aa_eff = 32'(MAX_AA);
      end else begin
         aa_eff = 32'(aa_ff);
      end
      if (width_ff == '0) begin
         width_eff = 32'd1;
      end else if (32'(width_ff) > 32'(MAX_OUT_WIDTH)) begin
         width_eff = 32'(MAX_OUT_WIDTH);
      end else begin
         width_eff = 32'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = 32'd1;
      end else if (32'(height_ff) > 32'(bfd_pkg::MAX_OUT_HEIGHT)) begin
         height_eff = 32'(bfd_pkg::MAX_OUT_HEIGHT);
      end else begin
         height_eff = 32'(height_ff);
      end
   end

   assign aa_last     = SUB_W'(aa_eff - 32'd1);
   assign width_last  = COL_W'(width_eff - 32'd1);
   assign height_last = bfd_pkg::ROW_W'(height_eff - 32'd1);

   // Rounded-up reciprocal of aa*aa for each factor, scaled by 2^SHIFT.
   for (genvar g = 1; g <= MAX_AA; g++) begin : g_recip
      localparam longint DIVISOR = longint'(g) * longint'(g);
      localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
      assign recip_table[g-1] = RECIP_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      recip_ff <= recip_table[aa_last];
   end

   bfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bfd_dpath #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_AA        (MAX_AA)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pixel_color (req_tdata),
      .aa_last     (aa_last),
      .width_last  (width_last),
      .height_last (height_last),
      .recip       (recip_ff),
      .avg_color   (rsp_tdata),
      .row_end     (rsp_tlast),
      .frame_end   (rsp_tuser[0])
   );

endmodule

[design/bfd_ctrl.sv]
// Controller state machine of the box filter downsampler.
// Depends on bfd_pkg; drives the datapath through dp_cmd_type.
module bfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output bfd_pkg::dp_cmd_type    cmd,
   input  bfd_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SUM   = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_wr = 1'b1;
            state_in   = status.emit ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The finished average waits here only while the output register is full.
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[design/bfd_dpath.sv]
// Datapath of the box filter downsampler: position counters, column sum memory,
// saturating accumulate, reciprocal multiply and the output register. Depends on bfd_pkg.
module bfd_dpath #(
   parameter  int MAX_OUT_WIDTH = 2048,
   parameter  int MAX_AA        = 8,
   localparam int SUB_W         = bfd_pkg::sub_width(MAX_AA),
   localparam int COL_W         = bfd_pkg::col_width(MAX_OUT_WIDTH),
   localparam int SUM_W         = bfd_pkg::sum_width(MAX_AA),
   localparam int SHIFT         = bfd_pkg::shift_width(MAX_AA),
   localparam int RECIP_W       = SHIFT + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfd_pkg::dp_cmd_type           cmd,
   output bfd_pkg::dp_status_type        status,
   input  logic [bfd_pkg::PIXEL_W-1:0]   pixel_color,
   input  logic [SUB_W-1:0]              aa_last,
   input  logic [COL_W-1:0]              width_last,
   input  logic [bfd_pkg::ROW_W-1:0]     height_last,
   input  logic [RECIP_W-1:0]            recip,
   output logic [bfd_pkg::PIXEL_W-1:0]   avg_color,
   output logic                          row_end,
   output logic                          frame_end
);

   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int QUO_W  = PROD_W - SHIFT;

   logic [SUB_W-1:0]          sub_col_ff, sub_col_in;
   logic [SUB_W-1:0]          sub_row_ff, sub_row_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [bfd_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      last_subcol, last_subrow, last_col, last_row;

   logic [bfd_pkg::PIXEL_W-1:0] px_ff;
   logic [COL_W-1:0]            addr_ff;
   logic                        emit_ff, row_end_ff, frame_end_ff;

   logic [COL_W-1:0] clr_ff, clr_in;

   logic [bfd_pkg::NUM_CHAN-1:0][SUM_W-1:0] mem [MAX_OUT_WIDTH];
   logic [bfd_pkg::NUM_CHAN-1:0][SUM_W-1:0] rd_ff;
   logic [bfd_pkg::NUM_CHAN-1:0][SUM_W-1:0] sum_in, sum_ff;
   logic [bfd_pkg::NUM_CHAN-1:0][SUM_W-1:0] wr_data;
   logic [bfd_pkg::NUM_CHAN-1:0][SUM_W:0]   sum_wide;
   logic [COL_W-1:0]                        wr_addr;
   logic                                    wr_en;

   logic [bfd_pkg::NUM_CHAN-1:0][PROD_W-1:0] prod_ff;
   logic [bfd_pkg::NUM_CHAN-1:0][QUO_W-1:0]  quo;
   logic [bfd_pkg::PIXEL_W-1:0]              avg_in, avg_ff;
   logic                                     out_row_end_ff, out_frame_end_ff;

   // Position tracking; a counter at or beyond its last value counts as last.
   always_comb begin
      last_subcol = (sub_col_ff >= aa_last);
      last_subrow = (sub_row_ff >= aa_last);
      last_col    = (col_ff >= width_last);
      last_row    = (row_ff >= height_last);
      sub_col_in  = sub_col_ff;
      sub_row_in  = sub_row_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (cmd.accept) begin
         if (!last_subcol) begin
            sub_col_in = sub_col_ff + 1'b1;
         end else begin
            sub_col_in = '0;
            if (!last_col) begin
               col_in = col_ff + 1'b1;
            end else begin
               col_in = '0;
               if (!last_subrow) begin
                  sub_row_in = sub_row_ff + 1'b1;
               end else begin
                  sub_row_in = '0;
                  row_in     = last_row ? '0 : row_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff <= '0;
         sub_row_ff <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         clr_ff     <= '0;
      end else begin
         sub_col_ff <= sub_col_in;
         sub_row_ff <= sub_row_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         clr_ff     <= clr_in;
      end
   end

   assign clr_in = cmd.clear_wr ? clr_ff + 1'b1 : clr_ff;
   assign status.clear_done = (clr_ff == COL_W'(MAX_OUT_WIDTH - 1));
   assign status.emit       = emit_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff        <= pixel_color;
         addr_ff      <= col_ff;
         emit_ff      <= last_subcol && last_subrow;
         row_end_ff   <= last_col;
         frame_end_ff <= last_col && last_row;
      end
   end

   // Saturating add; a saturated sum still divides to at least 255.
   always_comb begin
      for (int c = 0; c < bfd_pkg::NUM_CHAN; c++) begin
         sum_wide[c] = {1'b0, rd_ff[c]}
                     + (SUM_W + 1)'(px_ff[c*bfd_pkg::CHAN_W +: bfd_pkg::CHAN_W]);
         sum_in[c]   = sum_wide[c][SUM_W] ? '1 : sum_wide[c][SUM_W-1:0];
      end
   end

   assign wr_en   = cmd.clear_wr || cmd.sum_wr;
   assign wr_addr = cmd.clear_wr ? clr_ff : addr_ff;
   assign wr_data = (cmd.clear_wr || emit_ff) ? '0 : sum_in;

   // The read runs every cycle; the request's column is read at the accepting edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_wr) begin
         sum_ff <= sum_in;
      end
      if (cmd.mul) begin
         for (int c = 0; c < bfd_pkg::NUM_CHAN; c++) begin
            prod_ff[c] <= sum_ff[c] * recip;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < bfd_pkg::NUM_CHAN; c++) begin
         quo[c] = prod_ff[c][SHIFT +: QUO_W];
         avg_in[c*bfd_pkg::CHAN_W +: bfd_pkg::CHAN_W] =
            (|quo[c][QUO_W-1:bfd_pkg::CHAN_W]) ? '1 : quo[c][bfd_pkg::CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff           <= avg_in;
         out_row_end_ff   <= row_end_ff;
         out_frame_end_ff <= frame_end_ff;
      end
   end

   assign avg_color = avg_ff;
   assign row_end   = out_row_end_ff;
   assign frame_end = out_frame_end_ff;

endmodule

[design/bfd_port_checker.sv]
// Port-level assertions for the box filter downsampler, bound to its top level.
// Depends on box_filter_downsampler_macros.svh and bfd_pkg.
`include "box_filter_downsampler_macros.svh"

module bfd_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bfd_pkg::PIXEL_W-1:0]    rsp_tdata,
   input logic                           rsp_tlast,
   input logic [0:0]                     rsp_tuser
);

   // A held result keeps its payload until it is taken.
   `BFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // The sum memory is being cleared right after reset, so no request is taken.
   `BFD_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_tready, "request taken during clearing pass")

   // One request is worked on at a time.
   `BFD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "back to back requests accepted")

   // The last pixel of a frame is also the last pixel of its row.
   `BFD_ASSERT_NOW(a_frame_end_row_end, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast, "frame end without row end")

endmodule

bind box_filter_downsampler bfd_port_checker u_bfd_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
